>>> hdl/complex_carrier_pll_assert.svh
// Assertion macros shared by the complex carrier PLL RTL.
`ifndef COMPLEX_CARRIER_PLL_ASSERT_SVH
`define COMPLEX_CARRIER_PLL_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define CCP_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define CCP_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (expr)) \
        else $error(msg);

`endif

>>> hdl/ccp_pkg.sv
// Package: constants, CORDIC control struct and helper functions for the carrier PLL.
`timescale 1ns / 1ps
`default_nettype none
package ccp_pkg;

    localparam int PHASE_LUT_BITS  = 10;
    localparam int ATAN_ITERATIONS = 16;
    localparam int ROT_STEPS       = 24;
    localparam int XW              = 36;
    localparam int ZW              = 33;
    localparam logic signed [XW-1:0] CORDIC_K_Q30 = 36'sd652032874;

    typedef struct packed {
        logic                 load;
        logic                 step;
        logic                 vec_mode;
        logic [4:0]           idx;
        logic signed [XW-1:0] x0;
        logic signed [XW-1:0] y0;
        logic signed [ZW-1:0] z0;
    } cordic_ctl_t;

    // atan(2^-i) in turn units times 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // Q30 -> Q15, round half up, saturate to +-32767
    function automatic logic signed [15:0] to_q15(input logic signed [XW-1:0] v);
        logic signed [XW:0] t;
        logic signed [XW:0] r;
        logic signed [15:0] o;
        t = {v[XW-1], v} + (XW+1)'(16384);
        r = t >>> 15;
        if (r > (XW+1)'(32767))
            o = 16'sd32767;
        else if (r < -(XW+1)'(32767))
            o = -16'sd32767;
        else
            o = r[15:0];
        return o;
    endfunction

endpackage
`default_nettype wire

>>> hdl/ccp_cordic.sv
// Shared CORDIC add/shift unit, one micro-rotation per cycle while step is set, rotation or vectoring.
`timescale 1ns / 1ps
`default_nettype none
module ccp_cordic (
    input  wire                          aclk,
    input  ccp_pkg::cordic_ctl_t         ctl,
    output logic signed [ccp_pkg::XW-1:0] x_out,
    output logic signed [ccp_pkg::XW-1:0] y_out,
    output logic signed [ccp_pkg::ZW-1:0] z_out
);
    import ccp_pkg::*;

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    logic                 sigma;

    always_comb begin
        dx    = y_reg >>> ctl.idx;
        dy    = x_reg >>> ctl.idx;
        at    = {1'b0, atan_turn(ctl.idx)};
        // rotation drives z to zero, vectoring drives y to zero
        sigma = ctl.vec_mode ? y_reg[XW-1] : !z_reg[ZW-1];
        if (sigma) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - at;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            x_reg <= ctl.x0;
            y_reg <= ctl.y0;
            z_reg <= ctl.z0;
        end else if (ctl.step) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule
`default_nettype wire

>>> hdl/ccp_mul.sv
// Shared signed 33x18 multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module ccp_mul (
    input  wire                 aclk,
    input  logic signed [32:0]  mul_a,
    input  logic signed [17:0]  mul_b,
    output logic signed [50:0]  prod
);
    import ccp_pkg::*;

    logic signed [50:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

>>> hdl/complex_carrier_pll.sv
// Top level: carrier-tracking PLL with NCO, sequencing a shared CORDIC and multiplier.
// Usage:
//   Input stream s_*: one complex sample per transaction, tdata = {sample_q, sample_i}.
//   Output stream m_*: one result per input, tdata from bit 0 up: mixed_i, mixed_q,
//   phase_error, phase_step, nco_phase_out (32 bits each).
//   Config: cfg_wr_en/cfg_addr/cfg_wdata write center_increment (0, also loads the
//   phase step), low_limit (1), high_limit (2), loop_beta (3). Write only while idle.
// Sequence: from accept to result valid a sample runs 24 rotation steps on the CORDIC
//   unit for the NCO phasor, mixing on the single multiplier, 16 vectoring steps for
//   the angle, the loop filter and the output load. The block takes one sample at a
//   time; s_tready is high only when idle, so a new sample is accepted only once the
//   last one has been loaded into the output register.
// Output: results sit in an output register; the next sample is accepted while a
//   result waits. If the receiver stalls, a finished sample holds in its last step
//   until the output register frees.
// Reset: aresetn (synchronous, active low) clears the NCO phase and step, restores
//   the register defaults and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_carrier_pll_assert.svh"
module complex_carrier_pll (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [31:0]  s_tdata,    // sample_i [15:0], sample_q [31:16]
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [159:0] m_tdata,    // mixed_i, mixed_q, phase_error, phase_step, nco_phase_out
    input  wire          cfg_wr_en,
    input  wire  [1:0]   cfg_addr,
    input  wire  [31:0]  cfg_wdata
);
    import ccp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROT  = 3'd1;
    localparam logic [2:0] ST_MIX  = 3'd2;
    localparam logic [2:0] ST_VEC  = 3'd3;
    localparam logic [2:0] ST_FILT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [1:0] REG_CENTER = 2'd0;
    localparam logic [1:0] REG_LOW    = 2'd1;
    localparam logic [1:0] REG_HIGH   = 2'd2;
    localparam logic [1:0] REG_BETA   = 2'd3;

    logic [2:0]          state_reg;
    logic [4:0]          cnt_reg;
    logic signed [15:0]  si_reg, sq_reg;
    logic                flip_reg, zero_reg;
    logic signed [31:0]  mi_reg, mq_reg, err_reg;
    logic signed [50:0]  acc_reg;
    logic [31:0]         phase_reg;
    logic signed [31:0]  inc_reg;
    logic signed [31:0]  center_reg, low_reg, high_reg;
    logic [15:0]         beta_reg;
    logic                m_tvalid_reg;
    logic [159:0]        m_tdata_reg;

    cordic_ctl_t         ctl;
    logic signed [XW-1:0] cx, cy;
    logic signed [ZW-1:0] cz;
    logic signed [32:0]  mul_a;
    logic signed [17:0]  mul_b;
    logic signed [50:0]  prod;

    logic [31:0]         rot_a;
    logic                rot_flip;
    logic signed [15:0]  c_val, s_val;
    logic signed [31:0]  err_val;
    logic signed [50:0]  filt_sum;
    logic signed [34:0]  inc_w;
    logic                in_window;
    logic signed [31:0]  inc_new;

    ccp_cordic u_cordic (
        .aclk  (aclk),
        .ctl   (ctl),
        .x_out (cx),
        .y_out (cy),
        .z_out (cz)
    );

    ccp_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    always_comb begin
        rot_a    = {phase_reg[31:32-PHASE_LUT_BITS], {(32-PHASE_LUT_BITS){1'b0}}};
        // left half-plane: reduce by half a turn, negate phasor afterwards
        rot_flip = rot_a[31] ^ rot_a[30];
        c_val    = flip_reg ? -to_q15(cx) : to_q15(cx);
        s_val    = flip_reg ? -to_q15(cy) : to_q15(cy);
        err_val  = zero_reg ? 32'sd0 : -$signed(cz[31:0]);
        filt_sum = acc_reg + prod + 51'sd32768;
        inc_w    = filt_sum[50:16];
        in_window = (inc_w >= 35'(low_reg)) && (inc_w <= 35'(high_reg));
        inc_new  = in_window ? inc_w[31:0] : center_reg;
    end

    always_comb begin
        ctl          = '0;
        ctl.idx      = cnt_reg;
        ctl.vec_mode = (state_reg == ST_VEC);
        ctl.step     = (state_reg == ST_ROT) || (state_reg == ST_VEC);
        ctl.x0       = CORDIC_K_Q30;
        ctl.y0       = '0;
        ctl.z0       = ZW'($signed({rot_a[31] ^ rot_flip, rot_a[30:0]}));
        if (state_reg == ST_IDLE) begin
            ctl.load = s_tvalid && s_tready;
        end else if (state_reg == ST_MIX && cnt_reg == 5'd5) begin
            ctl.load = 1'b1;
            if (mi_reg[31]) begin
                ctl.x0 = -XW'(mi_reg);
                ctl.y0 = -XW'(mq_reg);
                ctl.z0 = {1'b0, 32'h80000000};
            end else begin
                ctl.x0 = XW'(mi_reg);
                ctl.y0 = XW'(mq_reg);
                ctl.z0 = '0;
            end
        end
    end

    always_comb begin
        mul_a = 33'(c_val);
        mul_b = 18'(si_reg);
        if (state_reg == ST_FILT) begin
            if (cnt_reg == 5'd0) begin
                mul_a = 33'(err_val);
                mul_b = $signed({1'b0, 17'(17'h10000 - {1'b0, beta_reg})});
            end else begin
                mul_a = 33'(inc_reg);
                mul_b = $signed({2'b00, beta_reg});
            end
        end else begin
            case (cnt_reg[1:0])
                2'd0:    begin mul_a = 33'(c_val); mul_b = 18'(si_reg); end
                2'd1:    begin mul_a = 33'(s_val); mul_b = 18'(sq_reg); end
                2'd2:    begin mul_a = 33'(c_val); mul_b = 18'(sq_reg); end
                default: begin mul_a = 33'(s_val); mul_b = 18'(si_reg); end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            phase_reg    <= '0;
            inc_reg      <= '0;
            center_reg   <= '0;
            low_reg      <= 32'sh80000000;
            high_reg     <= 32'sh7FFFFFFF;
            beta_reg     <= 16'd65000;
            m_tvalid_reg <= 1'b0;
        end else begin
            // in ST_DONE the output register is reloaded below instead
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        si_reg    <= $signed(s_tdata[15:0]);
                        sq_reg    <= $signed(s_tdata[31:16]);
                        flip_reg  <= rot_flip;
                        cnt_reg   <= '0;
                        state_reg <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    if (cnt_reg == 5'(ROT_STEPS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_MIX;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_MIX: begin
                    case (cnt_reg)
                        5'd1:    mi_reg <= prod[31:0];
                        5'd2:    mi_reg <= mi_reg - prod[31:0];
                        5'd3:    mq_reg <= prod[31:0];
                        5'd4:    mq_reg <= mq_reg + prod[31:0];
                        default: ;
                    endcase
                    if (cnt_reg == 5'd5) begin
                        zero_reg  <= (mi_reg == 32'sd0) && (mq_reg == 32'sd0);
                        cnt_reg   <= '0;
                        state_reg <= ST_VEC;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_VEC: begin
                    if (cnt_reg == 5'(ATAN_ITERATIONS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FILT;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_FILT: begin
                    if (cnt_reg == 5'd0)
                        err_reg <= err_val;
                    if (cnt_reg == 5'd1)
                        acc_reg <= prod;
                    if (cnt_reg == 5'd2) begin
                        inc_reg   <= inc_new;
                        phase_reg <= phase_reg + inc_new;
                        cnt_reg   <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {phase_reg, inc_reg, err_reg, mq_reg, mi_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_CENTER: begin
                        center_reg <= $signed(cfg_wdata);
                        inc_reg    <= $signed(cfg_wdata);
                    end
                    REG_LOW:  low_reg  <= $signed(cfg_wdata);
                    REG_HIGH: high_reg <= $signed(cfg_wdata);
                    REG_BETA: beta_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `CCP_ASSERT_NEXT(a_accept_starts_rot, s_tvalid && s_tready, state_reg == ST_ROT, "accepted sample did not start rotation")
    `CCP_ASSERT_ALWAYS(a_rot_count, state_reg != ST_ROT || cnt_reg < 5'(ROT_STEPS), "rotation step count out of range")
    `CCP_ASSERT_NEXT(a_done_holds, state_reg == ST_DONE && m_tvalid && !m_tready, state_reg == ST_DONE && m_tvalid, "result overwrote a pending output")

endmodule
`default_nettype wire

>>> verif/complex_carrier_pll_test.sv
// Testbench for complex_carrier_pll: random and directed I/Q samples checked against a carrier PLL predictor.
`timescale 1ns / 1ps
module complex_carrier_pll_test;
    import ccp_pkg::PHASE_LUT_BITS;
    import ccp_pkg::ATAN_ITERATIONS;
    import ccp_pkg::ROT_STEPS;

    typedef enum logic [1:0] {
        REG_CENTER = 2'd0,
        REG_LOW    = 2'd1,
        REG_HIGH   = 2'd2,
        REG_BETA   = 2'd3
    } cfg_reg_e;

    localparam int    WATCHDOG_LIMIT = 5000;
    localparam int    DRAIN_CYCLES   = 60;
    localparam longint NCO_GAIN_Q30  = 652032874;

    // atan(2^-i) in turns * 2^32
    localparam bit [31:0] ATAN_STEP [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [31:0] nco_phase_out;
        logic [31:0] phase_step;
        logic [31:0] phase_error;
        logic [31:0] mixed_q;
        logic [31:0] mixed_i;
    } pll_result_t;

    class pll_scoreboard;
        int signed   center_inc;
        int signed   low_lim;
        int signed   high_lim;
        bit [15:0]   beta;
        bit [31:0]   phase;
        int signed   step;
        pll_result_t pending_results[$];
        int          mismatches;

        function new();
            center_inc = 0;
            low_lim    = 32'sh80000000;
            high_lim   = 32'sh7FFFFFFF;
            beta       = 16'd65000;
            phase      = 0;
            step       = 0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_reg_e idx, logic [31:0] value);
            case (idx)
                REG_CENTER: begin
                    center_inc = value;
                    step       = value;
                end
                REG_LOW:  low_lim  = value;
                REG_HIGH: high_lim = value;
                REG_BETA: beta     = value[15:0];
                default: ;
            endcase
        endfunction

        function longint round_q15(longint v);
            longint r;
            r = (v + 16384) >>> 15;
            if (r > 32767) r = 32767;
            if (r < -32767) r = -32767;
            return r;
        endfunction

        function void nco_phasor(bit [31:0] ph, output longint c, output longint s);
            bit [31:0] a;
            bit        flip;
            longint    x, y, z, dx, dy;
            a = ph & (32'hFFFFFFFF << (32 - PHASE_LUT_BITS));
            flip = ((a + 32'h40000000) & 32'h80000000) != 0;
            if (flip) a = a - 32'h80000000;
            z = longint'($signed(a));
            x = NCO_GAIN_Q30;
            y = 0;
            for (int i = 0; i < ROT_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(ATAN_STEP[i]);
                end else begin
                    x += dx; y -= dy; z += longint'(ATAN_STEP[i]);
                end
            end
            c = round_q15(x);
            s = round_q15(y);
            if (flip) begin
                c = -c;
                s = -s;
            end
        endfunction

        function bit [31:0] vector_angle(longint x, longint y);
            bit [31:0] ang;
            longint    dx, dy;
            ang = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                x = -x; y = -y; ang = 32'h80000000;
            end
            for (int i = 0; i < ATAN_ITERATIONS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; ang += ATAN_STEP[i];
                end else begin
                    x -= dx; y += dy; ang -= ATAN_STEP[i];
                end
            end
            return ang;
        endfunction

        function void note_sample(logic [15:0] si_raw, logic [15:0] sq_raw);
            longint      si, sq, c, s, mi, mq, err, acc, inc;
            bit [31:0]   neg_ang;
            pll_result_t r;
            si = longint'($signed(si_raw));
            sq = longint'($signed(sq_raw));
            nco_phasor(phase, c, s);
            mi = c * si - s * sq;
            mq = c * sq + s * si;
            neg_ang = 32'd0 - vector_angle(mi, mq);
            err = longint'($signed(neg_ang));
            acc = err * (65536 - longint'(beta)) + longint'(step) * longint'(beta);
            inc = (acc + 32768) >>> 16;
            if (inc < longint'(low_lim) || inc > longint'(high_lim))
                inc = longint'(center_inc);
            step  = int'(inc);
            phase = phase + step;
            r.mixed_i       = mi[31:0];
            r.mixed_q       = mq[31:0];
            r.phase_error   = err[31:0];
            r.phase_step    = step;
            r.nco_phase_out = phase;
            pending_results.push_back(r);
        endfunction

        function void check_result(pll_result_t got);
            pll_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: mi %h/%h mq %h/%h err %h/%h step %h/%h ph %h/%h",
                             want.mixed_i, got.mixed_i, want.mixed_q, got.mixed_q,
                             want.phase_error, got.phase_error, want.phase_step,
                             got.phase_step, want.nco_phase_out, got.nco_phase_out);
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;      // sample_i [15:0], sample_q [31:16]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;           // mixed_i, mixed_q, phase_error, phase_step, nco_phase_out
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    pll_scoreboard pll_sb = new();
    bit            no_idle = 1'b0;
    int            quiet_cycles = 0;

    always #5 aclk = ~aclk;

    complex_carrier_pll i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // result side: random backpressure, check each transaction
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 29);
        if (aresetn && m_tvalid && m_tready)
            pll_sb.check_result(pll_result_t'(m_tdata));
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        pll_sb.write_reg(idx, value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample(logic [15:0] si, logic [15:0] sq);
        if (!no_idle && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sq, si};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pll_sb.note_sample(si, sq);
    endtask

    task automatic drain();
        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (pll_sb.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_component();
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(4))
            0:       return 32'h80000000;
            1:       return 32'h7FFFFFFF;
            2:       return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, extreme and zero samples
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h0001, 16'hFFFF);
        drain();
        write_reg(REG_CENTER, 32'h04000000);
        write_reg(REG_BETA, 16'd0);
        send_sample(16'h4000, 16'h0000);
        send_sample(16'h0000, 16'h4000);
        send_sample(16'h0000, 16'h0000);
        drain();
        write_reg(REG_BETA, 16'hFFFF);
        send_sample(16'hC000, 16'h1234);
        send_sample(16'h7FFF, 16'h0000);
        drain();
        // inverted window: every step reloads the center increment
        write_reg(REG_LOW, 32'h00001000);
        write_reg(REG_HIGH, 32'hFFFFF000);
        for (int k = 0; k < 5; k++) send_sample(rand_component(), rand_component());
        drain();
        write_reg(REG_LOW, 32'hFFF00000);
        write_reg(REG_HIGH, 32'h00100000);
        for (int k = 0; k < 5; k++) send_sample(rand_component(), rand_component());
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            no_idle = (ph == 3);
            write_reg(REG_CENTER, rand_word());
            if ($urandom_range(2) == 0) begin
                write_reg(REG_LOW, 32'h80000000);
                write_reg(REG_HIGH, 32'h7FFFFFFF);
            end else begin
                write_reg(REG_LOW, rand_word());
                write_reg(REG_HIGH, rand_word());
            end
            case (ph % 4)
                0:       write_reg(REG_BETA, 16'd0);
                1:       write_reg(REG_BETA, 16'hFFFF);
                default: write_reg(REG_BETA, 16'($urandom));
            endcase
            for (int k = 0; k < 200; k++) send_sample(rand_component(), rand_component());
            drain();
        end
        no_idle = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pll_sb.mismatches == 0 && pll_sb.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
